/* hw/rtl/assert_macros.svh */
// Assertion macros included by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, off while rst_n is low.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/itoa_pkg.sv */
// Shared types, codes and constants of the integer to ASCII formatter.
`default_nettype none

package itoa_pkg;

    // Format modes carried on cmd
    localparam logic [2:0] MODE_SDEC  = 3'd0;
    localparam logic [2:0] MODE_UDEC  = 3'd1;
    localparam logic [2:0] MODE_HEX32 = 3'd2;
    localparam logic [2:0] MODE_PTR   = 3'd3;
    localparam logic [2:0] MODE_CHAR  = 3'd4;

    // Fixed characters
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;

    // floor(x * RECIP_10 / 2**35) == floor(x / 10) for any 32-bit x
    localparam logic [31:0] RECIP_10   = 32'hcccc_cccd;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    localparam logic [7:0] HEX_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC_MUL,
        ST_DEC_DIV,
        ST_HEX_SKIP,
        ST_EMIT_MINUS,
        ST_EMIT_ZERO,
        ST_EMIT_X,
        ST_EMIT_DIGITS,
        ST_EMIT_RAW
    } state_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_MINUS,
        EM_ZERO,
        EM_X,
        EM_DIGIT,
        EM_RAW
    } emit_t;

    typedef struct packed {
        logic  load;       // capture a new input word
        logic  mul;        // reciprocal multiply of the magnitude
        logic  div;        // finish one decimal digit
        logic  shift_left; // drop the top nibble, count down
        emit_t emit;       // what goes to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a word
        logic top_zero;   // top nibble of the digit register is zero
        logic cnt_one;    // one digit left
        logic quot_zero;  // quotient of this step is zero
        logic neg;        // signed value was negative
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/itoa_datapath.sv */
// Datapath: magnitude, digit shift register, reciprocal multiplier, output register.
`default_nettype none

module itoa_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire itoa_pkg::dp_cmd_t   dp_cmd,
    output itoa_pkg::dp_status_t     dp_status,
    input  wire logic [2:0]          cmd,
    input  wire logic [63:0]         value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               ascii_char,
    output logic                     last
);

    logic [63:0]                 sr_reg, sr_next;
    logic [31:0]                 mag_reg, mag_next;
    logic [itoa_pkg::QUOT_W-1:0] quot_reg;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        out_valid_reg;
    logic [7:0]                  out_char_reg, out_char_next;
    logic                        out_last_reg, out_last_next;

    logic [63:0] prod;
    logic [31:0] quot_x10;
    logic [31:0] rem;
    logic [31:0] low32;

    assign low32    = value[31:0];
    assign prod     = mag_reg * itoa_pkg::RECIP_10;
    assign quot_x10 = {quot_reg, 3'b000} + {2'b00, quot_reg, 1'b0};
    assign rem      = mag_reg - quot_x10;

    always_comb
    begin
        sr_next  = sr_reg;
        mag_next = mag_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (dp_cmd.load)
        begin
            neg_next = (cmd == itoa_pkg::MODE_SDEC) && low32[31];
            mag_next = neg_next ? (32'd0 - low32) : low32;
            case (cmd)
                itoa_pkg::MODE_HEX32:
                begin
                    sr_next  = {low32, 32'd0};
                    cnt_next = 5'd8;
                end
                itoa_pkg::MODE_PTR:
                begin
                    sr_next  = value;
                    cnt_next = 5'd16;
                end
                itoa_pkg::MODE_CHAR:
                begin
                    sr_next  = {value[7:0], 56'd0};
                    cnt_next = 5'd1;
                end
                default:
                begin
                    sr_next  = 64'd0;
                    cnt_next = 5'd0;
                end
            endcase
        end
        else if (dp_cmd.div)
        begin
            // digits enter at the top, so the most significant ends up first
            sr_next  = {rem[3:0], sr_reg[63:4]};
            mag_next = 32'(quot_reg);
            cnt_next = cnt_reg + 5'd1;
        end
        else if (dp_cmd.shift_left)
        begin
            sr_next  = {sr_reg[59:0], 4'd0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_comb
    begin
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        unique case (dp_cmd.emit)
            itoa_pkg::EM_MINUS:
            begin
                out_char_next = itoa_pkg::CHAR_MINUS;
                out_last_next = 1'b0;
            end
            itoa_pkg::EM_ZERO:
            begin
                out_char_next = itoa_pkg::CHAR_ZERO;
                out_last_next = 1'b0;
            end
            itoa_pkg::EM_X:
            begin
                out_char_next = itoa_pkg::CHAR_X;
                out_last_next = 1'b0;
            end
            itoa_pkg::EM_DIGIT:
            begin
                out_char_next = itoa_pkg::HEX_TABLE[sr_reg[63:60]];
                out_last_next = (cnt_reg == 5'd1);
            end
            itoa_pkg::EM_RAW:
            begin
                out_char_next = sr_reg[63:56];
                out_last_next = 1'b1;
            end
            default:
            begin
                out_char_next = out_char_reg;
                out_last_next = out_last_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        mag_reg      <= mag_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (dp_cmd.mul)
        begin
            quot_reg <= prod[63:itoa_pkg::RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.emit != itoa_pkg::EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign dp_status.out_free  = !out_valid_reg || out_ready;
    assign dp_status.top_zero  = (sr_reg[63:60] == 4'd0);
    assign dp_status.cnt_one   = (cnt_reg == 5'd1);
    assign dp_status.quot_zero = (quot_reg == '0);
    assign dp_status.neg       = neg_reg;

    assign out_valid  = out_valid_reg;
    assign ascii_char = out_char_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/itoa_ctrl.sv */
// Controller state machine of the formatter.
`default_nettype none

module itoa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           cmd,
    input  wire itoa_pkg::dp_status_t dp_status,
    output itoa_pkg::dp_cmd_t         dp_cmd
);

    itoa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd) inside
                        itoa_pkg::MODE_SDEC, itoa_pkg::MODE_UDEC:
                            state_next = itoa_pkg::ST_DEC_MUL;
                        itoa_pkg::MODE_HEX32: state_next = itoa_pkg::ST_HEX_SKIP;
                        itoa_pkg::MODE_PTR:   state_next = itoa_pkg::ST_EMIT_ZERO;
                        itoa_pkg::MODE_CHAR:  state_next = itoa_pkg::ST_EMIT_RAW;
                        default:              state_next = itoa_pkg::ST_IDLE;
                    endcase
                end
            end
            itoa_pkg::ST_DEC_MUL:
                state_next = itoa_pkg::ST_DEC_DIV;
            itoa_pkg::ST_DEC_DIV:
            begin
                if (!dp_status.quot_zero)
                    state_next = itoa_pkg::ST_DEC_MUL;
                else if (dp_status.neg)
                    state_next = itoa_pkg::ST_EMIT_MINUS;
                else
                    state_next = itoa_pkg::ST_EMIT_DIGITS;
            end
            itoa_pkg::ST_HEX_SKIP:
            begin
                if (!dp_status.top_zero || dp_status.cnt_one)
                    state_next = itoa_pkg::ST_EMIT_DIGITS;
            end
            itoa_pkg::ST_EMIT_MINUS:
            begin
                if (dp_status.out_free)
                    state_next = itoa_pkg::ST_EMIT_DIGITS;
            end
            itoa_pkg::ST_EMIT_ZERO:
            begin
                if (dp_status.out_free)
                    state_next = itoa_pkg::ST_EMIT_X;
            end
            itoa_pkg::ST_EMIT_X:
            begin
                if (dp_status.out_free)
                    state_next = itoa_pkg::ST_EMIT_DIGITS;
            end
            itoa_pkg::ST_EMIT_DIGITS:
            begin
                if (dp_status.out_free && dp_status.cnt_one)
                    state_next = itoa_pkg::ST_IDLE;
            end
            itoa_pkg::ST_EMIT_RAW:
            begin
                if (dp_status.out_free)
                    state_next = itoa_pkg::ST_IDLE;
            end
            default:
                state_next = itoa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        dp_cmd   = '{load: 1'b0, mul: 1'b0, div: 1'b0, shift_left: 1'b0,
                     emit: itoa_pkg::EM_NONE};
        in_ready = 1'b0;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                dp_cmd.load = in_valid;
            end
            itoa_pkg::ST_DEC_MUL:
                dp_cmd.mul = 1'b1;
            itoa_pkg::ST_DEC_DIV:
                dp_cmd.div = 1'b1;
            itoa_pkg::ST_HEX_SKIP:
                dp_cmd.shift_left = dp_status.top_zero && !dp_status.cnt_one;
            itoa_pkg::ST_EMIT_MINUS:
                if (dp_status.out_free) dp_cmd.emit = itoa_pkg::EM_MINUS;
            itoa_pkg::ST_EMIT_ZERO:
                if (dp_status.out_free) dp_cmd.emit = itoa_pkg::EM_ZERO;
            itoa_pkg::ST_EMIT_X:
                if (dp_status.out_free) dp_cmd.emit = itoa_pkg::EM_X;
            itoa_pkg::ST_EMIT_DIGITS:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.emit       = itoa_pkg::EM_DIGIT;
                    dp_cmd.shift_left = 1'b1;
                end
            end
            itoa_pkg::ST_EMIT_RAW:
                if (dp_status.out_free) dp_cmd.emit = itoa_pkg::EM_RAW;
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter: controller plus datapath.
// One word at a time, chars at most one per cycle while the output is not stalled. Decimal
//   runs one multiply and one remainder step per digit and adds '-' when negative; hex32
//   skips leading zero nibbles; an unused mode is dropped. Reset: rst_n async, active low,
//   clears the state machine and output valid.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel: one word = mode plus operand
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [63:0] value,
    // output channel: one word = one character
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       ascii_char,
    output logic             last
);

    itoa_pkg::dp_cmd_t    dp_cmd;
    itoa_pkg::dp_status_t dp_status;

    // Sequencer: decodes the mode, runs the digit loop and paces emission
    // against the output register.
    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Datapath: decimal digits come LSB first from a reciprocal divide by ten
    // and are pushed into the top of a nibble shift register, so every digit mode
    // emits its digits from the top nibble downward; char mode emits the top byte.
    itoa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .cmd        (cmd),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

`default_nettype wire

/* hw/rtl/itoa_checker.sv */
// Port-level checker of the formatter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module itoa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [2:0]  cmd,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  ascii_char,
    input wire logic        last
);

    logic in_acc;
    logic good_acc;
    logic bad_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign good_acc  = in_acc && (cmd <= itoa_pkg::MODE_CHAR);
    assign bad_acc   = in_acc && (cmd > itoa_pkg::MODE_CHAR);
    assign out_stall = out_valid && !out_ready;

    `ASSERT_IMPL(a_out_hold, out_stall, out_valid, "output word dropped")
    `ASSERT_IMPL(a_out_stable, out_stall, $stable(ascii_char) && $stable(last), "output changed")
    `ASSERT_IMPL(a_busy, good_acc, !in_ready, "idle right after a valid mode")
    `ASSERT_IMPL(a_bad_mode, bad_acc, in_ready && !$rose(out_valid), "unused mode made work")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

`default_nettype wire

/* tb/integer_to_ascii_formatter_tb.sv */
// Self-checking testbench of the integer to ASCII formatter: directed table, then random words.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 350;
    localparam int PHASE_WORDS  = RANDOM_WORDS / 4;
    // Watchdog limit on a full run, including heavy stalls; allow plenty of margin.
    localparam int CYCLE_LIMIT  = 600000;
    // Longest run is a ten digit decimal with minus.
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 30;

    // One expected output word: character byte plus end-of-run flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_word_t;

    // One directed row. When typed is set, text holds the exact expected run
    // (empty text means no output at all); otherwise the predictor decides.
    typedef struct {
        logic [2:0]  mode;
        logic [63:0] operand;
        bit          typed;
        string       text;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  ascii_char;
    logic        last;

    char_word_t  pending_chars[$];  // characters still owed by the block
    logic [7:0]  digit_text[$];     // scratch run built by the predictor
    vector_t     vectors[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;

    integer_to_ascii_formatter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char),
        .last       (last)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'd0, nib};
        else
            return 8'h61 + {4'd0, nib} - 8'd10;
    endfunction

    // Append digits of mag in radix 10 or 16, most significant first, no leading zeros.
    task automatic append_digits(input logic [31:0] mag, input int radix);
        logic [7:0] rev[$];
        logic [31:0] rest;
        rest = mag;
        do begin
            rev.push_back(nibble_char(4'(rest % radix)));
            rest = rest / radix;
        end while (rest != 32'd0);
        while (rev.size() != 0)
            digit_text.push_back(rev.pop_back());
    endtask

    // Work out the character run of one accepted word and queue it.
    task automatic format_operand(input logic [2:0] mode, input logic [63:0] operand);
        logic [31:0] low32;
        low32 = operand[31:0];
        digit_text.delete();
        case (mode)
            itoa_pkg::MODE_SDEC:
            begin
                if (low32[31])
                begin
                    digit_text.push_back(itoa_pkg::CHAR_MINUS);
                    // unsigned negate keeps the most negative value correct
                    append_digits(32'd0 - low32, 10);
                end
                else
                begin
                    append_digits(low32, 10);
                end
            end
            itoa_pkg::MODE_UDEC:  append_digits(low32, 10);
            itoa_pkg::MODE_HEX32: append_digits(low32, 16);
            itoa_pkg::MODE_PTR:
            begin
                digit_text.push_back(itoa_pkg::CHAR_ZERO);
                digit_text.push_back(itoa_pkg::CHAR_X);
                for (int k = 15; k >= 0; k--)
                    digit_text.push_back(nibble_char(operand[4*k +: 4]));
            end
            itoa_pkg::MODE_CHAR:  digit_text.push_back(operand[7:0]);
            default:    ; // unused modes are dropped
        endcase
        for (int i = 0; i < digit_text.size(); i++)
            pending_chars.push_back('{digit_text[i], i == digit_text.size() - 1});
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{text[i], i == text.len() - 1});
    endtask

    // ------------------------------------------------------------------
    // Input driver: one word per call, valid kept high across back-to-back words
    // ------------------------------------------------------------------

    task automatic send_word(input logic [2:0] mode, input logic [63:0] operand,
                             input bit typed, input string text);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= mode;
        value    <= operand;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            queue_text(text);
        else
            format_operand(mode, operand);
    endtask

    // Random operand with a spread of digit counts and sign edges.
    function automatic logic [63:0] pick_operand();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return full;
            1: return {full[63:32], 32'($urandom_range(99))};
            2: return {full[63:32], 32'($urandom_range(999999))};
            3: return full >> $urandom_range(63);
            4: return {full[63:32], 32'h8000_0000 + 32'($urandom_range(15))};
            5: return {full[63:32], 32'h7fff_ffff - 32'($urandom_range(15))};
            6: return {full[63:32], 32'd0 - 32'($urandom_range(1, 1000))};
            default: return (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word: expected none, got char %h last %b",
                             $time, ascii_char, last);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (ascii_char !== want.ch)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: ascii_char mismatch: expected %h, got %h",
                                 $time, want.ch, ascii_char);
                end
                if (last !== want.fin)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, want.fin, last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** integer_to_ascii_formatter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int sent;
        logic [2:0] mode;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = itoa_pkg::MODE_SDEC;
        value    = 64'd0;

        // Directed table: extremes, every mode, ignored modes and upper bits.
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'd0, 1, "0"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'h0000_0000_7fff_ffff, 1, "2147483647"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'h0000_0000_8000_0000, 1, "-2147483648"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'h0000_0000_ffff_ffff, 1, "-1"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'hffff_ffff_0000_0005, 1, "5"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'h0000_0000_ffff_fff6, 1, "-10"});
        vectors.push_back('{itoa_pkg::MODE_SDEC, 64'd12345, 0, ""});
        vectors.push_back('{itoa_pkg::MODE_UDEC, 64'd0, 1, "0"});
        vectors.push_back('{itoa_pkg::MODE_UDEC, 64'h0000_0000_ffff_ffff, 1, "4294967295"});
        vectors.push_back('{itoa_pkg::MODE_UDEC, 64'hdead_beef_0000_000a, 1, "10"});
        vectors.push_back('{itoa_pkg::MODE_UDEC, 64'd1000000000, 0, ""});
        vectors.push_back('{itoa_pkg::MODE_HEX32, 64'd0, 1, "0"});
        vectors.push_back('{itoa_pkg::MODE_HEX32, 64'h0000_0000_ffff_ffff, 1, "ffffffff"});
        vectors.push_back('{itoa_pkg::MODE_HEX32, 64'h1234_5678_0000_abcd, 1, "abcd"});
        vectors.push_back('{itoa_pkg::MODE_HEX32, 64'h0000_0000_0000_0010, 1, "10"});
        vectors.push_back('{itoa_pkg::MODE_PTR, 64'd0, 1, "0x0000000000000000"});
        vectors.push_back('{itoa_pkg::MODE_PTR, 64'hffff_ffff_ffff_ffff, 1,
                            "0xffffffffffffffff"});
        vectors.push_back('{itoa_pkg::MODE_PTR, 64'h0123_4567_89ab_cdef, 1,
                            "0x0123456789abcdef"});
        vectors.push_back('{itoa_pkg::MODE_CHAR, 64'd0, 0, ""});
        vectors.push_back('{itoa_pkg::MODE_CHAR, 64'hffff_ffff_ffff_ffff, 0, ""});
        vectors.push_back('{itoa_pkg::MODE_CHAR, 64'hffff_ffff_ffff_ff41, 1, "A"});
        // unused modes produce nothing
        vectors.push_back('{3'd5, 64'hffff_ffff_ffff_ffff, 1, ""});
        vectors.push_back('{3'd6, 64'd0, 1, ""});
        vectors.push_back('{3'd7, 64'h8000_0000_0000_0001, 1, ""});
        vectors.push_back('{itoa_pkg::MODE_CHAR, 64'h0000_0000_0000_0030, 1, "0"});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send_word(vectors[i].mode, vectors[i].operand, vectors[i].typed, vectors[i].text);

        // Hold off until the block has drained everything it owes.
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);

        // Random part in four idling phases: none, sender gaps, receiver stalls, light both.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (sent / PHASE_WORDS)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin sender_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            if ($urandom_range(99) < 5)
            begin
                // noise: an unused mode, does not count as a real word
                mode = 3'($urandom_range(7, int'(itoa_pkg::MODE_CHAR) + 1));
            end
            else
            begin
                mode = 3'($urandom_range(int'(itoa_pkg::MODE_CHAR)));
                sent++;
            end
            send_word(mode, pick_operand(), 0, "");
        end

        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("** integer_to_ascii_formatter: PASSED **");
        else
            $display("** integer_to_ascii_formatter: FAILED **");
        $finish;
    end

endmodule
